[rtl/tpsd_pkg.sv]
package tpsd_pkg;

  // Window geometry: a frame is fully decided by the newest FRAME_SPAN bytes.
  localparam int WINDOW_BYTES_DEF = 11;
  localparam int FRAME_SPAN       = 9;
  localparam int NUM_DIGITS       = 6;
  localparam int POS_W            = 3;
  localparam int IDLE_W           = 16;

  localparam logic [POS_W-1:0]  LAST_POS      = 3'd5;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = 16'hFFFF;
  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 16'h01FF;

  localparam logic [7:0] CHECK_BASE = 8'd64;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] ASCII_NL   = 8'h0A;
  localparam logic [7:0] ASCII_SP   = 8'h20;
  localparam logic [7:0] ASCII_A    = 8'h41;
  localparam logic [7:0] ASCII_Z    = 8'h5A;

  localparam logic [7:0] SEG_G = 8'h20;
  localparam logic [7:0] SEG_P = 8'h80;

  localparam logic [5:0] ALL_OFF_N = 6'h3F;

  // Dashes everywhere, with points on the minutes position (0) and on position 2.
  localparam logic [NUM_DIGITS-1:0][7:0] DASH_SET = {
    SEG_G, SEG_G, SEG_G, SEG_G | SEG_P, SEG_G, SEG_G | SEG_P
  };

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } tpsd_in_t;

  typedef struct packed {
    logic       scan_valid;
    logic [7:0] segments;
    logic [5:0] digit_enable_n;
    logic       frame_accepted;
    logic       timed_out;
  } tpsd_out_t;

  typedef struct packed {
    logic                         ok;
    logic [NUM_DIGITS-1:0][7:0]   pats;
  } frame_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // Segment font for an ASCII digit (low nibble is the digit value).
  function automatic logic [7:0] glyph(input logic [7:0] c);
    logic [7:0] g;
    case (c[3:0])
      4'd0:    g = 8'h5F;
      4'd1:    g = 8'h0C;
      4'd2:    g = 8'h79;
      4'd3:    g = 8'h7C;
      4'd4:    g = 8'h2E;
      4'd5:    g = 8'h76;
      4'd6:    g = 8'h77;
      4'd7:    g = 8'h4C;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h7E;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

[rtl/tpsd_frame_chk.sv]
module tpsd_frame_chk (
  input  logic [tpsd_pkg::FRAME_SPAN-1:0][7:0] win,
  output tpsd_pkg::frame_res_t                 res
);
  import tpsd_pkg::*;

  logic       run5, run6;
  logic [7:0] sum5, sum6, status, mins_c, tens_c;
  logic       status_ok, sum_ok, mins_nz, tens_nz;
  logic [NUM_DIGITS-1:0][7:0] src;

  // Digit run length: exactly five or six digits starting after the checksum.
  assign run5 = is_digit(win[2]) && is_digit(win[3]) && is_digit(win[4]) &&
                is_digit(win[5]) && is_digit(win[6]) && !is_digit(win[7]);
  assign run6 = is_digit(win[2]) && is_digit(win[3]) && is_digit(win[4]) &&
                is_digit(win[5]) && is_digit(win[6]) && is_digit(win[7]) &&
                !is_digit(win[8]);

  // Checksum is 64 plus the sum of the digit values, modulo 256.
  assign sum5 = CHECK_BASE + {4'd0, win[2][3:0]} + {4'd0, win[3][3:0]} +
                {4'd0, win[4][3:0]} + {4'd0, win[5][3:0]} + {4'd0, win[6][3:0]};
  assign sum6 = sum5 + {4'd0, win[7][3:0]};

  assign status    = run6 ? win[8] : win[7];
  assign status_ok = (status == ASCII_SP) || ((status >= ASCII_A) && (status <= ASCII_Z));
  assign sum_ok    = (win[1] == (run6 ? sum6 : sum5));

  // Position p shows the byte that is p places after the oldest digit.
  always_comb begin
    for (int p = 0; p < NUM_DIGITS - 1; p++) begin
      src[p] = run6 ? win[7-p] : win[6-p];
    end
    src[NUM_DIGITS-1] = win[2];
  end

  assign mins_c  = src[0];
  assign tens_c  = src[1];
  assign mins_nz = (mins_c[3:0] != 4'd0);
  assign tens_nz = (tens_c[3:0] != 4'd0);

  // Frame verdict, then leading-zero blanking on the first two positions and
  // points on 0 and 2; position 5 is blank for a five-digit run.
  always_comb begin
    res.ok      = (win[0] == ASCII_NL) && (run5 || run6) && sum_ok && status_ok;
    res.pats[0] = mins_nz ? (glyph(mins_c) | SEG_P) : 8'h00;
    res.pats[1] = (mins_nz || tens_nz) ? glyph(tens_c) : 8'h00;
    res.pats[2] = glyph(src[2]) | SEG_P;
    res.pats[3] = glyph(src[3]);
    res.pats[4] = glyph(src[4]);
    res.pats[5] = run6 ? glyph(src[5]) : 8'h00;
  end

endmodule

[rtl/timer_packet_seven_segment_driver.sv]
// An accepted request is held in the input register, then its result in the
// result register. Throughput: one request per cycle, bytes and scan ticks
// alike, unless out_stall holds the result; the frame check is a fixed set of
// compares over the newest nine window bytes.
// Reset (rst_n low, synchronous): window cleared, dash pattern shown, scan at
// position 0, idle count saturated, timeout limit 511, both registers empty.
module timer_packet_seven_segment_driver #(
  parameter int WINDOW_BYTES = tpsd_pkg::WINDOW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpsd_pkg::tpsd_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpsd_pkg::tpsd_out_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import tpsd_pkg::*;

  logic                       in_vld_r;
  tpsd_in_t                   in_r;
  logic                       out_vld_r;
  tpsd_out_t                  out_r, out_nxt;
  logic [WINDOW_BYTES-1:0][7:0] win_r, win_nxt;
  logic [NUM_DIGITS-1:0][7:0] pat_r, pat_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [IDLE_W-1:0]          idle_r, idle_nxt, idle_inc;
  logic [IDLE_W-1:0]          limit_r;
  logic                       adv, proc;
  frame_res_t                 frame;

  // The result register moves when empty or taken; the input register refills
  // whenever its request moves on.
  assign adv      = !out_vld_r || !out_stall;
  assign proc     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Window after shifting in the held byte.
  always_comb begin
    win_nxt[0] = in_r.rx_byte;
    for (int i = 1; i < WINDOW_BYTES; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  tpsd_frame_chk u_frame_chk (
    .win (win_nxt[FRAME_SPAN-1:0]),
    .res (frame)
  );

  // Per-request processing.
  always_comb begin
    pat_nxt  = pat_r;
    pos_nxt  = pos_r;
    idle_nxt = idle_r;
    idle_inc = (idle_r < IDLE_MAX) ? idle_r + 16'd1 : idle_r;

    out_nxt                = '0;
    out_nxt.digit_enable_n = ALL_OFF_N;

    if (in_r.func) begin
      out_nxt.scan_valid = 1'b1;
      if (pos_r <= LAST_POS) begin
        out_nxt.segments       = pat_r[pos_r];
        out_nxt.digit_enable_n = ~(6'd1 << pos_r);
      end
      pos_nxt  = (pos_r >= LAST_POS) ? '0 : pos_r + 3'd1;
      idle_nxt = idle_inc;
      if (idle_inc > limit_r) begin
        pat_nxt           = DASH_SET;
        out_nxt.timed_out = 1'b1;
      end
    end else begin
      out_nxt.frame_accepted = frame.ok;
      if (frame.ok) begin
        pat_nxt  = frame.pats;
        idle_nxt = '0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

  // Block state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      pat_r   <= DASH_SET;
      pos_r   <= '0;
      idle_r  <= IDLE_MAX;
      limit_r <= TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (proc) begin
        if (!in_r.func) begin
          win_r <= win_nxt;
        end
        pat_r  <= pat_nxt;
        pos_r  <= pos_nxt;
        idle_r <= idle_nxt;
      end
    end
  end

  // The scan position never leaves the six digit positions.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("scan position out of range");

  // A frame result is never a scan result.
  a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.frame_accepted && out_r.scan_valid))
    else $error("frame and scan flags both set");

  // A scan result lights exactly one digit.
  a_scan_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.scan_valid) |-> $onehot(~out_r.digit_enable_n))
    else $error("scan enables not one-hot");

  // An accepted frame clears the idle count.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !in_r.func && frame.ok) |=> (idle_r == '0))
    else $error("idle count not cleared by frame");

  // A timeout shows dashes on the next cycle.
  a_dash_restore: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && out_nxt.timed_out) |=> (pat_r == DASH_SET))
    else $error("dash pattern not restored");

endmodule
